// File: hdl/stca_pkg.sv
// ----------------------------------------------------------------------------
// stca_pkg
// Shared widths, register codes and sequencer states for the temperature
// compensation and averaging block.
// ----------------------------------------------------------------------------
package stca_pkg;

  localparam int unsigned SAMPLES_DEF = 10;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned REG_IDX_W = 2;

  // (raw - ac6) is 17 bits signed, times a 16-bit unsigned gain
  localparam int unsigned DIFF_W   = DATA_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + DATA_W;
  localparam int unsigned X1_SHIFT = 15;
  localparam int unsigned X1_W     = PROD_W - X1_SHIFT;

  // x1 + md, and the magnitude of mc * 2^11
  localparam int unsigned DVS_W    = X1_W + 1;
  localparam int unsigned MC_SHIFT = 11;
  localparam int unsigned DVD_W    = DATA_W + MC_SHIFT;

  localparam int unsigned B5_W    = DVD_W + 1;
  localparam int unsigned T_SHIFT = 4;
  localparam int unsigned T_ROUND = 8;
  localparam int unsigned T_W     = B5_W - T_SHIFT;

  localparam int unsigned MUL_STEPS = DATA_W;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_AC5 = 2'd0,
    REG_AC6 = 2'd1,
    REG_MC  = 2'd2,
    REG_MD  = 2'd3
  } cfg_reg_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_PREP = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_TVAL = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_WEND = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

// File: hdl/sensor_temp_compensate_average.sv
// ----------------------------------------------------------------------------
// sensor_temp_compensate_average
// Compensates raw barometric-sensor temperature samples with four calibration
// words and emits the truncated mean over a window of samples.
// ----------------------------------------------------------------------------
// Each sample is handled one at a time by a bit-serial datapath: a shift-add
// multiplier forms (raw - ac6) * ac5, and a restoring divider that retires one
// quotient bit per cycle forms (mc << 11) / (x1 + md). A sample occupies the
// block from acceptance until it is accumulated, and only then can the next
// sample be taken; a sample whose divisor is zero skips the divider. The
// sample that closes a window reuses the same divider to form the mean, after
// which the result sits in an output register while the next window already
// runs. A zero divisor gives x2 = 0 and sets div_fault on that window's result.
// Calibration registers must be written by the user through cfg_we / cfg_idx /
// cfg_data only while the block is idle; the block itself does not enforce it.
module sensor_temp_compensate_average
  import stca_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_RESULT = SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    raw_temp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DATA_W-1:0] avg_temp,
  output logic                 div_fault
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_RESULT + 1);
  localparam int unsigned SUM_W = DATA_W + $clog2(SAMPLES_PER_RESULT);

  logic [DATA_W-1:0]        cal_ac5;
  logic [DATA_W-1:0]        cal_ac6;
  logic signed [DATA_W-1:0] cal_mc;
  logic signed [DATA_W-1:0] cal_md;

  state_t                   state;
  logic [STEP_W-1:0]        step;
  logic [CNT_W-1:0]         cnt;
  logic signed [SUM_W-1:0]  sum;
  logic                     fault_seen;

  // serial multiplier
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] mcand;
  logic [DATA_W-1:0]        mplier;

  // serial divider
  logic [DVD_W-1:0]         quo;
  logic [DVS_W-1:0]         rem;
  logic [DVS_W-1:0]         dvs;
  logic                     quo_neg;
  logic                     div_mean;

  logic signed [X1_W-1:0]   x1;
  logic                     zdiv;
  logic signed [DATA_W-1:0] t_sat;

  // combinational datapath
  logic signed [DIFF_W-1:0] diff_in;
  logic signed [PROD_W-1:0] mul_add;
  logic signed [X1_W-1:0]   x1_w;
  logic signed [DVS_W-1:0]  dsum;
  logic [DVS_W-1:0]         dsum_mag;
  logic [DATA_W-1:0]        mc_mag;
  logic [DVS_W:0]           shifted;
  logic [DVS_W+1:0]         trial;
  logic signed [B5_W-1:0]   q_signed;
  logic signed [B5_W-1:0]   x2_w;
  logic signed [B5_W-1:0]   b5r;
  logic signed [T_W-1:0]    t_full;
  logic signed [DATA_W-1:0] t_clip;
  logic signed [SUM_W-1:0]  sum_add;
  logic [SUM_W-1:0]         sum_mag;
  logic [CNT_W-1:0]         cnt_inc;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    diff_in  = $signed({1'b0, raw_temp}) - $signed({1'b0, cal_ac6});
    mul_add  = acc + (mplier[0] ? mcand : '0);
    // arithmetic shift by 15 is a floor
    x1_w     = acc[PROD_W-1 -: X1_W];
    dsum     = DVS_W'(x1_w) + DVS_W'(cal_md);
    dsum_mag = dsum[DVS_W-1] ? DVS_W'(-dsum) : DVS_W'(dsum);
    mc_mag   = cal_mc[DATA_W-1] ? DATA_W'(-cal_mc) : DATA_W'(cal_mc);

    // one restoring step: bring in the next dividend bit, try to subtract
    shifted  = {rem, quo[DVD_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs};

    q_signed = quo_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    x2_w     = zdiv ? '0 : q_signed;
    b5r      = B5_W'(x1) + x2_w + B5_W'(T_ROUND);
    t_full   = b5r[B5_W-1:T_SHIFT];
    if (!t_full[T_W-1] && (|t_full[T_W-2:DATA_W-1])) begin
      t_clip = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (t_full[T_W-1] && !(&t_full[T_W-2:DATA_W-1])) begin
      t_clip = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      t_clip = t_full[DATA_W-1:0];
    end

    sum_add  = sum + SUM_W'(t_sat);
    sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    cnt_inc  = cnt + CNT_W'(1);
  end

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac5 <= '0;
      cal_ac6 <= '0;
      cal_mc  <= '0;
      cal_md  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_AC5: cal_ac5 <= cfg_data;
        REG_AC6: cal_ac6 <= cfg_data;
        REG_MC:  cal_mc  <= $signed(cfg_data);
        REG_MD:  cal_md  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      cnt        <= '0;
      sum        <= '0;
      fault_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // S_OUT loads the next result itself
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            step  <= STEP_W'(MUL_STEPS);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step - STEP_W'(1);
          if (step == STEP_W'(1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (dsum == '0) begin
            state <= S_TVAL;
          end else begin
            step  <= STEP_W'(DIV_STEPS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          step <= step - STEP_W'(1);
          if (step == STEP_W'(1)) begin
            state <= div_mean ? S_OUT : S_TVAL;
          end
        end
        S_TVAL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          sum        <= sum_add;
          cnt        <= cnt_inc;
          fault_seen <= fault_seen | zdiv;
          state      <= (cnt_inc == CNT_W'(SAMPLES_PER_RESULT)) ? S_WEND : S_IDLE;
        end
        S_WEND: begin
          step  <= STEP_W'(DIV_STEPS);
          state <= S_DIV;
        end
        S_OUT: begin
          // hold the mean until the output register is free
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            cnt        <= '0;
            sum        <= '0;
            fault_seen <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        acc    <= '0;
        mcand  <= PROD_W'(diff_in);
        mplier <= cal_ac5;
      end
      S_MUL: begin
        acc    <= mul_add;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
      end
      S_PREP: begin
        x1       <= x1_w;
        zdiv     <= (dsum == '0);
        quo      <= {mc_mag, {MC_SHIFT{1'b0}}};
        rem      <= '0;
        dvs      <= dsum_mag;
        quo_neg  <= cal_mc[DATA_W-1] ^ dsum[DVS_W-1];
        div_mean <= 1'b0;
      end
      S_DIV: begin
        rem <= trial[DVS_W+1] ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], ~trial[DVS_W+1]};
      end
      S_TVAL: begin
        t_sat <= t_clip;
      end
      S_WEND: begin
        quo      <= DVD_W'(sum_mag);
        rem      <= '0;
        dvs      <= DVS_W'(SAMPLES_PER_RESULT);
        quo_neg  <= sum[SUM_W-1];
        div_mean <= 1'b1;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          avg_temp  <= q_signed[DATA_W-1:0];
          div_fault <= fault_seen;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL))
    else $error("accepted transaction did not start the multiplier");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output state");

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    (cnt <= CNT_W'(SAMPLES_PER_RESULT)))
    else $error("sample count passed the window size");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=>
      ($past(step) == STEP_W'(1)) ||
      ((state == S_DIV) && (step == $past(step) - STEP_W'(1))))
    else $error("divider left early or skipped a step");

  a_window_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ((cnt == '0) && (sum == '0) && !fault_seen))
    else $error("window state not cleared with the result");
`endif

endmodule
